// ===== src/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk, ignored while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge of clk, including during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/csvft_pkg.sv =====
// Types and constants for the CSV field tokenizer.
`default_nettype none

package csvft_pkg;

    localparam int DATA_W  = 16;
    localparam int KIND_W  = 3;
    localparam int STATE_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [DATA_W-1:0] QUOTE_CODE = 16'h0022;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_JOIN_CHAR = 1'b1;

    localparam logic [DATA_W-1:0] SEPARATOR_RST = 16'd44;
    localparam logic [DATA_W-1:0] JOIN_CHAR_RST = 16'd10;

    // Parser states
    localparam logic [STATE_W-1:0] ST_REC_START   = 3'd0;
    localparam logic [STATE_W-1:0] ST_FIELD_START = 3'd1;
    localparam logic [STATE_W-1:0] ST_UNQUOTED    = 3'd2;
    localparam logic [STATE_W-1:0] ST_QUOTED      = 3'd3;
    localparam logic [STATE_W-1:0] ST_QUOTE_SEEN  = 3'd4;
    localparam logic [STATE_W-1:0] ST_SKIP        = 3'd5;

    // Result kinds
    localparam logic [KIND_W-1:0] K_CHAR         = 3'd0;
    localparam logic [KIND_W-1:0] K_FIELD_END    = 3'd1;
    localparam logic [KIND_W-1:0] K_RECORD_END   = 3'd2;
    localparam logic [KIND_W-1:0] K_EMPTY_RECORD = 3'd3;
    localparam logic [KIND_W-1:0] K_CONTINUE     = 3'd4;
    localparam logic [KIND_W-1:0] K_REJECT       = 3'd5;

    typedef struct packed {
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] data;
    } csvft_res_t;

endpackage

`default_nettype wire

// ===== src/csvft_ifs.sv =====
// Channel interfaces: input word, result word and configuration write.
`default_nettype none

interface csvft_item_if
    import csvft_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [DATA_W-1:0] character;

    modport source (output valid, output action, output character, input ready);
    modport sink   (input valid, input action, input character, output ready);
endinterface

interface csvft_result_if
    import csvft_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data;

    modport source (output valid, output kind, output data, input ready);
    modport sink   (input valid, input kind, input data, output ready);
endinterface

interface csvft_cfg_if
    import csvft_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/csvft_step.sv =====
// Next-state and result decode for one input word of the tokenizer.
`default_nettype none

module csvft_step
    import csvft_pkg::*;
#(
    parameter int CHAR_WIDTH = 16
)
(
    input  wire logic [STATE_W-1:0] state,
    input  wire logic               action,
    input  wire logic [DATA_W-1:0]  character,
    input  wire logic [DATA_W-1:0]  separator,
    input  wire logic [DATA_W-1:0]  join_char,
    output      logic [STATE_W-1:0] state_next,
    output      csvft_res_t         res
);

    localparam int CMP_W = (CHAR_WIDTH < DATA_W) ? CHAR_WIDTH : DATA_W;
    localparam logic [DATA_W-1:0] CHAR_MASK = DATA_W'((32'd1 << CMP_W) - 32'd1);

    logic [DATA_W-1:0]  c_m;
    logic [DATA_W-1:0]  sep_m;
    logic [DATA_W-1:0]  join_m;
    logic [STATE_W-1:0] st;
    logic               is_quote;
    logic               is_sep;

    assign c_m      = character & CHAR_MASK;
    assign sep_m    = separator & CHAR_MASK;
    assign join_m   = join_char & CHAR_MASK;
    assign is_quote = (c_m == QUOTE_CODE);
    assign is_sep   = (c_m == sep_m);
    // Unused encodings behave as record start
    assign st       = (state > ST_SKIP) ? ST_REC_START : state;

    always_comb
    begin
        state_next = st;
        res.emit   = 1'b0;
        res.kind   = K_CHAR;
        res.data   = '0;
        if (action)
        begin
            unique case (st)
                ST_QUOTED:
                begin
                    res.emit = 1'b1;
                    res.kind = K_CONTINUE;
                    res.data = join_m;
                end
                ST_SKIP:
                begin
                    state_next = ST_REC_START;
                end
                ST_REC_START:
                begin
                    res.emit = 1'b1;
                    res.kind = K_EMPTY_RECORD;
                end
                default:
                begin
                    state_next = ST_REC_START;
                    res.emit   = 1'b1;
                    res.kind   = K_RECORD_END;
                end
            endcase
        end
        else
        begin
            unique case (st) inside
                ST_REC_START, ST_FIELD_START:
                begin
                    if (is_quote)
                    begin
                        state_next = ST_QUOTED;
                    end
                    else if (is_sep)
                    begin
                        state_next = ST_FIELD_START;
                        res.emit   = 1'b1;
                        res.kind   = K_FIELD_END;
                    end
                    else
                    begin
                        state_next = ST_UNQUOTED;
                        res.emit   = 1'b1;
                        res.data   = c_m;
                    end
                end
                ST_UNQUOTED:
                begin
                    res.emit = 1'b1;
                    if (is_sep)
                    begin
                        state_next = ST_FIELD_START;
                        res.kind   = K_FIELD_END;
                    end
                    else if (is_quote)
                    begin
                        state_next = ST_SKIP;
                        res.kind   = K_REJECT;
                    end
                    else
                    begin
                        res.data = c_m;
                    end
                end
                ST_QUOTED:
                begin
                    if (is_quote)
                    begin
                        state_next = ST_QUOTE_SEEN;
                    end
                    else
                    begin
                        res.emit = 1'b1;
                        res.data = c_m;
                    end
                end
                ST_QUOTE_SEEN:
                begin
                    res.emit = 1'b1;
                    if (is_quote)
                    begin
                        state_next = ST_QUOTED;
                        res.data   = QUOTE_CODE;
                    end
                    else if (is_sep)
                    begin
                        state_next = ST_FIELD_START;
                        res.kind   = K_FIELD_END;
                    end
                    else
                    begin
                        state_next = ST_SKIP;
                        res.kind   = K_REJECT;
                    end
                end
                default:
                begin
                    state_next = ST_SKIP;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/csv_field_tokenizer_unit.sv =====
// Top level of the streaming CSV field tokenizer.
`default_nettype none
`include "assert_macros.svh"

// Streaming CSV tokenizer. Each input word is a character or an end-of-line
// mark (action = 1); each produces zero or one result word: a field character,
// a field end, a field-and-record end, an empty record, a line continuation
// inside quotes (data = join character) or a record reject. After a reject the
// rest of the line is dropped silently. Throughput is one word per cycle with
// no bubbles while the result side is ready; a word passes the input register
// and then the result register around the single state-update stage. The result
// register decouples the two sides, so one new word is accepted while a
// finished result still waits. Separator (index 0, reset 44) and join
// character (index 1, reset 10) are written through the cfg channel, always
// ready; write them only while the block is idle. Characters and the
// separator are compared, and the join character is output, on their low
// CHAR_WIDTH bits.
module csv_field_tokenizer_unit
    import csvft_pkg::*;
#(
    parameter int CHAR_WIDTH = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    csvft_item_if.sink      item,
    csvft_result_if.source  result,
    csvft_cfg_if.sink       cfg
);

    // Configuration registers
    logic [DATA_W-1:0] sep_reg;
    logic [DATA_W-1:0] join_reg;

    // Input register
    logic              in_valid_reg;
    logic              in_action_reg;
    logic [DATA_W-1:0] in_char_reg;

    // Parser state and result register
    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [DATA_W-1:0]  out_data_reg;

    csvft_res_t res;
    logic       advance;

    // Advance the input register into the result stage when the result slot
    // is free or being drained this cycle.
    assign advance    = !out_valid_reg || result.ready;
    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    assign result.valid = out_valid_reg;
    assign result.kind  = out_kind_reg;
    assign result.data  = out_data_reg;

    csvft_step #(
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_step (
        .state      (state_reg),
        .action     (in_action_reg),
        .character  (in_char_reg),
        .separator  (sep_reg),
        .join_char  (join_reg),
        .state_next (state_next),
        .res        (res)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg  <= SEPARATOR_RST;
            join_reg <= JOIN_CHAR_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SEPARATOR: sep_reg  <= cfg.data;
                CFG_JOIN_CHAR: join_reg <= cfg.data;
                default:       ;
            endcase
        end
    end

    // Capture the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_action_reg <= item.action;
            in_char_reg   <= item.character;
        end
    end

    // Update the parser state and load the result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_REC_START;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && res.emit;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && res.emit)
        begin
            out_kind_reg <= res.kind;
            out_data_reg <= res.data;
        end
    end

    `ASSERT_CLK(a_state_legal, state_reg <= ST_SKIP, "parser state left the legal range")
    `ASSERT_CLK(a_data_zero,
        result.valid && result.kind != K_CHAR && result.kind != K_CONTINUE
            |-> result.data == '0,
        "nonzero data on a result kind without payload")
    `ASSERT_CLK(a_reject_skips,
        advance && in_valid_reg && res.emit && res.kind == K_REJECT
            |=> state_reg == ST_SKIP,
        "reject did not enter line skip")
    `ASSERT_CLK(a_hold_input,
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_char_reg)
            && $stable(in_action_reg),
        "stalled input word was lost or changed")

endmodule

`default_nettype wire
